@@ hw/rtl/pfa_pkg.sv @@
// pfa_pkg: shared types and constants of the physical frame allocator
// no dependencies; used by pfa_addr_chk, the allocator unit, the port checker and the bench
`timescale 1ns / 1ps
`default_nettype none

package pfa_pkg;

  localparam int unsigned ADDR_W      = 39;
  localparam int unsigned BASE_W      = 27;
  localparam int unsigned FC_W        = 13;
  localparam int unsigned FRAME_SHIFT = 12;
  localparam int unsigned FRAME_BYTES = 4096;
  localparam int unsigned CMD_W       = 2;
  localparam int unsigned STATUS_W    = 3;

  // command codes carried in s_tuser
  localparam logic [CMD_W-1:0] CMD_INIT    = 2'd0;
  localparam logic [CMD_W-1:0] CMD_GET     = 2'd1;
  localparam logic [CMD_W-1:0] CMD_RELEASE = 2'd2;

  // configuration register indexes
  localparam logic CFG_BASE  = 1'b0;
  localparam logic CFG_COUNT = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_NO_FREE      = 3'd1,
    ST_MISALIGNED   = 3'd2,
    ST_OUT_OF_RANGE = 3'd3,
    ST_DOUBLE_FREE  = 3'd4,
    ST_NULL         = 3'd5,
    ST_NO_ROOM      = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_INIT
  } state_t;

  // release address check result
  typedef struct packed {
    status_t             status;
    logic [BASE_W-1:0]   offset;
  } chk_res_t;

endpackage

`default_nettype wire

@@ hw/rtl/pfa_mem.sv @@
// pfa_mem: simple dual-port synchronous ram, one write and one registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module pfa_mem #(
  parameter int unsigned DEPTH = 4096,
  parameter int unsigned WIDTH = 14
) (
  input  wire logic                     clk,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] ram [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ram[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= ram[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/pfa_addr_chk.sv @@
// pfa_addr_chk: validates a release address against the region registers
// depends on pfa_pkg
`timescale 1ns / 1ps
`default_nettype none

module pfa_addr_chk (
  input  wire logic [pfa_pkg::ADDR_W-1:0] frame_address,
  input  wire logic [pfa_pkg::BASE_W-1:0] base_frame_number,
  input  wire logic [pfa_pkg::FC_W-1:0]   eff_count,
  output pfa_pkg::chk_res_t                res
);

  logic [pfa_pkg::BASE_W-1:0] fn;
  logic [pfa_pkg::BASE_W-1:0] offset;

  assign fn     = frame_address[pfa_pkg::ADDR_W-1:pfa_pkg::FRAME_SHIFT];
  assign offset = fn - base_frame_number;

  always_comb begin
    res.offset = offset;
    if (frame_address == '0) begin
      res.status = pfa_pkg::ST_NULL;
    end else if (frame_address[pfa_pkg::FRAME_SHIFT-1:0] != '0) begin
      res.status = pfa_pkg::ST_MISALIGNED;
    end else if ((fn < base_frame_number) ||
                 (offset >= pfa_pkg::BASE_W'(eff_count))) begin
      res.status = pfa_pkg::ST_OUT_OF_RANGE;
    end else begin
      res.status = pfa_pkg::ST_OK;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/physical_frame_allocator_unit.sv @@
// physical_frame_allocator_unit: 4 KiB frame allocator, free list plus used map in one ram
// depends on pfa_pkg, pfa_mem, pfa_addr_chk
//
// usage:
//   s_* channel takes commands: s_tuser = command (init, get, release),
//   s_tdata = frame address for release. m_* channel returns one result per
//   command: m_tdata = granted address, m_tuser = status code.
//   cfg_* channel writes base_frame_number (index 0) and frame_count (index 1);
//   write only while no command is in flight.
// sequence:
//   get and release: the accept cycle reads the link/used word of the head or
//   released frame, then the EXEC state writes it back and loads the result
//   register once the output register is free. init sweeps every ram entry
//   once through the single write port, then loads its result the same way.
//   after reset a clearing pass over every ram entry marks every frame used;
//   s_tready stays low during it, configuration writes are taken.
// stalls:
//   the result sits in an output register; a new command is taken while it
//   waits, and the next result holds back until m_tready frees the register.
`timescale 1ns / 1ps
`default_nettype none

module physical_frame_allocator_unit #(
  parameter int unsigned MAX_FRAMES = 4096
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // command in
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,   // [38:0] frame_address
  input  wire logic [1:0]  s_tuser,   // [1:0] command
  // result out
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [39:0] m_tdata,   // [38:0] granted_address
  output logic      [2:0]  m_tuser,   // [2:0] status
  // configuration writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic        cfg_index,
  input  wire logic [26:0] cfg_data
);

  localparam int unsigned IDX_W = $clog2(MAX_FRAMES);
  localparam int unsigned LW    = IDX_W + 1;
  localparam int unsigned MW    = LW + 1;
  localparam int unsigned EFF_W = (IDX_W + 1 < pfa_pkg::FC_W) ? IDX_W + 1 : pfa_pkg::FC_W;
  localparam logic [LW-1:0]    END_LINK = LW'(MAX_FRAMES);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_FRAMES - 1);

  pfa_pkg::state_t state, state_next;

  logic [IDX_W-1:0]           cnt;
  logic [IDX_W-1:0]           head_index, head_index_next;
  logic                       head_valid, head_valid_next;
  logic                       head_load;
  logic [pfa_pkg::BASE_W-1:0] base_frame_number;
  logic [pfa_pkg::FC_W-1:0]   frame_count;

  logic [pfa_pkg::CMD_W-1:0]  cmd_q;
  pfa_pkg::status_t           chk_status_q;
  logic [IDX_W-1:0]           rel_idx_q;
  logic [EFF_W-1:0]           n_q;
  logic [EFF_W-1:0]           res_q;

  logic [EFF_W-1:0]           eff_count;
  logic [31:0]                res_calc;
  pfa_pkg::chk_res_t          chk;

  logic                       rd_en;
  logic [IDX_W-1:0]           rd_addr;
  logic [MW-1:0]              rd_data;
  logic                       rd_used;
  logic [LW-1:0]              rd_link;
  logic                       wr_en;
  logic [IDX_W-1:0]           wr_addr;
  logic [MW-1:0]              wr_data;

  logic                       accept;
  logic                       out_free;
  logic                       out_load;
  logic [pfa_pkg::ADDR_W-1:0] out_addr;
  pfa_pkg::status_t           out_status;
  logic                       sweep_last;
  logic                       sweep_used;
  logic [LW-1:0]              sweep_link;
  logic [pfa_pkg::BASE_W-1:0] grant_fn;

  assign cfg_ready = 1'b1;

  assign eff_count = (32'(frame_count) > MAX_FRAMES) ? EFF_W'(MAX_FRAMES)
                                                     : frame_count[EFF_W-1:0];
  // frames holding a one-bit-per-frame map: ceil(ceil(n/8)/4096)
  assign res_calc  = (((32'(eff_count) + 32'd7) >> 3) + 32'(pfa_pkg::FRAME_BYTES - 1))
                     >> pfa_pkg::FRAME_SHIFT;

  pfa_addr_chk u_addr_chk (
    .frame_address     (s_tdata[pfa_pkg::ADDR_W-1:0]),
    .base_frame_number (base_frame_number),
    .eff_count         (pfa_pkg::FC_W'(eff_count)),
    .res               (chk)
  );

  // word layout: used bit on top, next link below
  pfa_mem #(
    .DEPTH (MAX_FRAMES),
    .WIDTH (MW)
  ) u_mem (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  assign rd_used = rd_data[MW-1];
  assign rd_link = rd_data[LW-1:0];

  assign accept     = s_tvalid && s_tready;
  assign out_free   = !m_tvalid || m_tready;
  assign sweep_last = (cnt == LAST_IDX);
  assign sweep_used = (32'(cnt) < 32'(res_q)) || (32'(cnt) >= 32'(n_q));
  assign sweep_link = ((32'(cnt) + 32'd1) < 32'(n_q)) ? LW'(32'(cnt) + 32'd1) : END_LINK;
  assign grant_fn   = base_frame_number + pfa_pkg::BASE_W'(head_index);

  always_comb begin
    state_next      = state;
    s_tready        = 1'b0;
    rd_en           = 1'b0;
    rd_addr         = head_index;
    wr_en           = 1'b0;
    wr_addr         = cnt;
    wr_data         = {1'b1, END_LINK};
    out_load        = 1'b0;
    out_addr        = '0;
    out_status      = pfa_pkg::ST_OK;
    head_load       = 1'b0;
    head_index_next = head_index;
    head_valid_next = head_valid;
    unique case (state)
      pfa_pkg::S_CLEAR: begin
        wr_en = 1'b1;
        if (sweep_last) begin
          state_next = pfa_pkg::S_IDLE;
        end
      end
      pfa_pkg::S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          rd_en = (s_tuser == pfa_pkg::CMD_GET) || (s_tuser == pfa_pkg::CMD_RELEASE);
          if (s_tuser == pfa_pkg::CMD_RELEASE) begin
            rd_addr = chk.offset[IDX_W-1:0];
          end
          state_next = (s_tuser == pfa_pkg::CMD_INIT) ? pfa_pkg::S_INIT : pfa_pkg::S_EXEC;
        end
      end
      pfa_pkg::S_INIT: begin
        wr_en   = 1'b1;
        wr_data = {sweep_used, sweep_link};
        if (sweep_last) begin
          state_next = pfa_pkg::S_EXEC;
        end
      end
      pfa_pkg::S_EXEC: begin
        if (out_free) begin
          out_load   = 1'b1;
          state_next = pfa_pkg::S_IDLE;
          unique case (cmd_q)
            pfa_pkg::CMD_INIT: begin
              head_load = 1'b1;
              if (res_q >= n_q) begin
                out_status      = pfa_pkg::ST_NO_ROOM;
                head_index_next = '0;
                head_valid_next = 1'b0;
              end else begin
                head_index_next = IDX_W'(res_q);
                head_valid_next = 1'b1;
              end
            end
            pfa_pkg::CMD_GET: begin
              if (!head_valid) begin
                out_status = pfa_pkg::ST_NO_FREE;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = head_index;
                wr_data   = {1'b1, rd_link};
                out_addr  = {grant_fn, {pfa_pkg::FRAME_SHIFT{1'b0}}};
                head_load = 1'b1;
                if (rd_link < END_LINK) begin
                  head_index_next = rd_link[IDX_W-1:0];
                end else begin
                  head_index_next = '0;
                  head_valid_next = 1'b0;
                end
              end
            end
            pfa_pkg::CMD_RELEASE: begin
              if (chk_status_q != pfa_pkg::ST_OK) begin
                out_status = chk_status_q;
              end else if (!rd_used) begin
                out_status = pfa_pkg::ST_DOUBLE_FREE;
              end else begin
                wr_en           = 1'b1;
                wr_addr         = rel_idx_q;
                wr_data         = {1'b0, head_valid ? LW'(head_index) : END_LINK};
                head_load       = 1'b1;
                head_index_next = rel_idx_q;
                head_valid_next = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      default: state_next = pfa_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pfa_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // sweep counter shared by the clearing pass and init
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (state == pfa_pkg::S_CLEAR || state == pfa_pkg::S_INIT) begin
      cnt <= sweep_last ? '0 : cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head_index <= '0;
      head_valid <= 1'b0;
    end else if (head_load) begin
      head_index <= head_index_next;
      head_valid <= head_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      base_frame_number <= '0;
      frame_count       <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        pfa_pkg::CFG_BASE:  base_frame_number <= cfg_data;
        pfa_pkg::CFG_COUNT: frame_count       <= cfg_data[pfa_pkg::FC_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q        <= s_tuser;
      chk_status_q <= chk.status;
      rel_idx_q    <= chk.offset[IDX_W-1:0];
      n_q          <= eff_count;
      res_q        <= EFF_W'(res_calc);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      m_tdata <= {1'b0, out_addr};
      m_tuser <= out_status;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/pfa_chk.sv @@
// pfa_chk: port-level checks of the frame allocator, bound to the top level
// depends on pfa_pkg and physical_frame_allocator_unit
`timescale 1ns / 1ps
`default_nettype none

module pfa_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [39:0] m_tdata,
  input wire logic [2:0]  m_tuser
);

  // stalled result must hold
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("result changed while stalled");

  // only a successful get carries an address
  a_addr_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata != '0) |-> m_tuser == pfa_pkg::ST_OK)
    else $error("address returned with error status");

  // granted addresses are frame aligned
  a_addr_align: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[pfa_pkg::FRAME_SHIFT-1:0] == '0)
    else $error("granted address not frame aligned");

  // one command in flight: no transfer in the cycle after a transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second command taken while one is in flight");

endmodule

bind physical_frame_allocator_unit pfa_chk u_pfa_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

@@ tb/sv/physical_frame_allocator_unit_tb.sv @@
// physical_frame_allocator_unit_tb: self-checking bench for the frame allocator
// keeps its own copy of the free list and used bits and checks every result in order
// depends on pfa_pkg and physical_frame_allocator_unit
`timescale 1ns / 1ps

module physical_frame_allocator_unit_tb;

  localparam int unsigned FRAMES         = 4096;
  localparam int unsigned LINK_END       = FRAMES;
  localparam logic [1:0]  CMD_UNUSED     = 2'd3;
  localparam int unsigned RX_HOLD_CYCLES = 400;
  localparam int unsigned WATCHDOG_LIMIT = 25000;
  localparam int unsigned SEGMENT_ITEMS  = 167;

  typedef struct packed {
    logic [38:0]      granted;
    pfa_pkg::status_t status;
  } frame_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic [1:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [26:0] cfg_data = '0;

  // allocator state as the bench sees it
  logic [12:0] model_next [0:FRAMES-1];
  bit          model_used [0:FRAMES-1];
  logic [11:0] model_head;
  bit          model_head_ok;
  logic [26:0] model_base;
  logic [12:0] model_count;

  frame_result_t pending_results [$];
  int unsigned   errors = 0;
  int unsigned   stall_cycles = 0;
  int unsigned   tx_idle_pct = 0;
  int unsigned   rx_idle_pct = 0;
  bit            rx_hold_req = 1'b0;
  int unsigned   rx_hold_left = 0;

  physical_frame_allocator_unit #(
    .MAX_FRAMES(FRAMES)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [38:0] frame_addr(input logic [63:0] frame_no);
    logic [63:0] wide;
    wide = frame_no << pfa_pkg::FRAME_SHIFT;
    return wide[38:0];
  endfunction

  function automatic logic [38:0] random_addr();
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return r[38:0];
  endfunction

  function automatic int unsigned model_frames();
    return (model_count > FRAMES) ? FRAMES : int'(model_count);
  endfunction

  function automatic frame_result_t predict_frame_result(input logic [1:0] cmd,
                                                         input logic [38:0] addr);
    frame_result_t r;
    int unsigned   n;
    int unsigned   rsv;
    int unsigned   idx;
    logic [63:0]   fn;
    r.granted = '0;
    r.status  = pfa_pkg::ST_OK;
    n = model_frames();
    case (cmd)
      pfa_pkg::CMD_INIT: begin
        rsv = ((n + 7) / 8 + pfa_pkg::FRAME_BYTES - 1) / pfa_pkg::FRAME_BYTES;
        for (int i = 0; i < FRAMES; i++) model_used[i] = 1'b1;
        model_head_ok = 1'b0;
        model_head    = '0;
        if (rsv >= n) begin
          r.status = pfa_pkg::ST_NO_ROOM;
        end else begin
          for (int unsigned i = rsv; i < n; i++) begin
            model_next[i] = (i + 1 < n) ? 13'(i + 1) : 13'(LINK_END);
            model_used[i] = 1'b0;
          end
          model_head    = 12'(rsv);
          model_head_ok = 1'b1;
        end
      end
      pfa_pkg::CMD_GET: begin
        if (!model_head_ok) begin
          r.status = pfa_pkg::ST_NO_FREE;
        end else begin
          idx = model_head;
          model_used[idx] = 1'b1;
          if (model_next[idx] < LINK_END) begin
            model_head = model_next[idx][11:0];
          end else begin
            model_head    = '0;
            model_head_ok = 1'b0;
          end
          r.granted = frame_addr(64'(model_base) + idx);
        end
      end
      pfa_pkg::CMD_RELEASE: begin
        fn = 64'(addr[38:12]);
        if (addr == '0) begin
          r.status = pfa_pkg::ST_NULL;
        end else if (addr[11:0] != '0) begin
          r.status = pfa_pkg::ST_MISALIGNED;
        end else if (fn < 64'(model_base) || fn - 64'(model_base) >= n) begin
          r.status = pfa_pkg::ST_OUT_OF_RANGE;
        end else begin
          idx = int'(fn - 64'(model_base));
          if (!model_used[idx]) begin
            r.status = pfa_pkg::ST_DOUBLE_FREE;
          end else begin
            // freed frame goes on top of the list
            model_next[idx] = model_head_ok ? {1'b0, model_head} : 13'(LINK_END);
            model_head      = 12'(idx);
            model_head_ok   = 1'b1;
            model_used[idx] = 1'b0;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // prefers a frame that is currently handed out, so the release goes through
  function automatic logic [38:0] pick_used_frame_addr();
    int unsigned n;
    int unsigned idx;
    logic [38:0] addr;
    n = model_frames();
    addr = random_addr();
    for (int t = 0; t < 16 && n > 0; t++) begin
      idx = $urandom_range(n - 1);
      if (model_used[idx]) begin
        addr = frame_addr(64'(model_base) + idx);
        break;
      end
    end
    return addr;
  endfunction

  task automatic send_command(input logic [1:0] cmd, input logic [38:0] addr);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= cmd;
    s_tdata  <= {1'b0, addr};
    do @(posedge clk); while (s_tready !== 1'b1);
    pending_results.push_back(predict_frame_result(cmd, addr));
  endtask

  task automatic write_register(input logic idx, input logic [26:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx == pfa_pkg::CFG_BASE) model_base = value;
    else model_count = value[12:0];
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic wait_results_drained();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic reconfigure(input logic [26:0] base, input logic [26:0] count);
    wait_results_drained();
    write_register(pfa_pkg::CFG_BASE, base);
    write_register(pfa_pkg::CFG_COUNT, count);
  endtask

  // registers still at reset: empty list, nothing in range
  task automatic test_before_init();
    send_command(pfa_pkg::CMD_GET, '0);
    send_command(pfa_pkg::CMD_RELEASE, '0);
    send_command(pfa_pkg::CMD_RELEASE, 39'h1000);
    send_command(CMD_UNUSED, '1);
  endtask

  // regions with no room, one frame and two frames
  task automatic test_tiny_regions();
    reconfigure(27'd5, 27'd0);
    send_command(pfa_pkg::CMD_INIT, '0);
    reconfigure(27'd5, 27'd1);
    send_command(pfa_pkg::CMD_INIT, '1);
    send_command(pfa_pkg::CMD_RELEASE, frame_addr(5));
    send_command(pfa_pkg::CMD_GET, '0);
    reconfigure(27'd5, 27'd2);
    send_command(pfa_pkg::CMD_INIT, '0);
    send_command(pfa_pkg::CMD_GET, '0);
    send_command(pfa_pkg::CMD_GET, '0);
    send_command(pfa_pkg::CMD_RELEASE, frame_addr(6));
    send_command(pfa_pkg::CMD_RELEASE, frame_addr(6));
    send_command(pfa_pkg::CMD_RELEASE, frame_addr(5));
    send_command(pfa_pkg::CMD_GET, '0);
    send_command(pfa_pkg::CMD_GET, '0);
    send_command(pfa_pkg::CMD_RELEASE, 39'h7F_FFFF_FFFF);
    send_command(pfa_pkg::CMD_RELEASE, frame_addr(4));
    send_command(pfa_pkg::CMD_RELEASE, frame_addr(7));
  endtask

  // top base with an oversized count, granted addresses wrap around
  task automatic test_address_extremes();
    reconfigure('1, 27'd8191);
    send_command(pfa_pkg::CMD_INIT, '0);
    send_command(pfa_pkg::CMD_GET, '0);
    send_command(pfa_pkg::CMD_GET, '0);
    send_command(pfa_pkg::CMD_RELEASE, 39'h7F_FFFF_F000);
    send_command(pfa_pkg::CMD_RELEASE, 39'h1000);
  endtask

  // output held off while commands keep coming, then a full drain
  task automatic test_full_stall();
    reconfigure(27'($urandom()), 27'd24);
    send_command(pfa_pkg::CMD_INIT, '0);
    wait_results_drained();
    tx_idle_pct = 0;
    rx_hold_req = 1'b1;
    for (int k = 0; k < 12; k++) begin
      if (k % 3 == 2) send_command(pfa_pkg::CMD_RELEASE, pick_used_frame_addr());
      else send_command(pfa_pkg::CMD_GET, random_addr());
    end
    wait_results_drained();
  endtask

  task automatic run_random_segment(input int unsigned items);
    int unsigned pick;
    int unsigned n;
    logic [26:0] base;
    logic [26:0] count;
    logic [38:0] addr;
    case ($urandom_range(3))
      0:       base = '0;
      1:       base = '1;
      default: base = 27'($urandom());
    endcase
    case ($urandom_range(9))
      0:       count = 27'($urandom_range(1));
      1:       count = 27'(FRAMES);
      2:       count = 27'($urandom());
      default: count = 27'($urandom_range(48, 2));
    endcase
    reconfigure(base, count);
    if ($urandom_range(4) != 0) send_command(pfa_pkg::CMD_INIT, random_addr());
    for (int unsigned k = 0; k < items; k++) begin
      pick = $urandom_range(99);
      n = model_frames();
      if (pick < 42 || (pick >= 97 && pick < 99)) begin
        send_command(pfa_pkg::CMD_GET, random_addr());
      end else if (pick < 78) begin
        send_command(pfa_pkg::CMD_RELEASE, pick_used_frame_addr());
      end else if (pick < 83) begin
        // any frame of the region, mostly already free
        addr = (n > 0) ? frame_addr(64'(model_base) + $urandom_range(n - 1)) : random_addr();
        send_command(pfa_pkg::CMD_RELEASE, addr);
      end else if (pick < 88) begin
        addr = random_addr();
        if (addr[11:0] == '0) addr[0] = 1'b1;
        send_command(pfa_pkg::CMD_RELEASE, addr);
      end else if (pick < 92) begin
        if ($urandom_range(1) == 0) begin
          addr = random_addr();
          addr[11:0] = '0;
        end else begin
          addr = frame_addr(64'(model_base) + n);
        end
        send_command(pfa_pkg::CMD_RELEASE, addr);
      end else if (pick < 94) begin
        send_command(pfa_pkg::CMD_RELEASE, '0);
      end else if (pick < 97) begin
        send_command(CMD_UNUSED, random_addr());
      end else begin
        send_command(pfa_pkg::CMD_INIT, random_addr());
      end
    end
  endtask

  task automatic test_random_traffic(input int unsigned tx_pct, input int unsigned rx_pct);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    repeat (3) run_random_segment(SEGMENT_ITEMS);
  endtask

  // result sink with random back-pressure and an occasional long hold
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (rx_hold_left > 0) begin
      m_tready     <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else if (rx_hold_req) begin
      rx_hold_req = 1'b0;
      rx_hold_left <= RX_HOLD_CYCLES;
      m_tready     <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin : check_results
    frame_result_t want;
    if (!rst && m_tvalid === 1'b1 && m_tready === 1'b1) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with none pending, address %h status %0d",
                 $time, m_tdata[38:0], m_tuser);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[38:0] !== want.granted) begin
          $display("%0t: granted_address expected %h actual %h",
                   $time, want.granted, m_tdata[38:0]);
          errors++;
        end
        if (m_tuser !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status, m_tuser);
          errors++;
        end
      end
    end
  end

  // ends the run when no transfer of any kind happens for too long
  always @(posedge clk) begin
    if ((s_tvalid === 1'b1 && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready === 1'b1)
        || (cfg_valid === 1'b1 && cfg_ready === 1'b1)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("physical_frame_allocator_unit_tb NOT OK");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < FRAMES; i++) begin
      model_next[i] = '0;
      model_used[i] = 1'b1;
    end
    model_head    = '0;
    model_head_ok = 1'b0;
    model_base    = '0;
    model_count   = '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    test_before_init();
    test_tiny_regions();
    test_address_extremes();
    test_full_stall();
    test_random_traffic(24, 55);
    test_random_traffic(55, 24);
    test_random_traffic(0, 0);
    wait_results_drained();
    repeat (16) @(posedge clk);
    if (errors == 0) begin
      $display("physical_frame_allocator_unit_tb OK");
    end else begin
      $display("physical_frame_allocator_unit_tb NOT OK");
    end
    $finish;
  end

endmodule
